// File: src/ipe_pkg.sv
// shared types and constants of the indexed pixel expander
// no dependencies; used by every module of the block but ipe_palette_ram
package ipe_pkg;

  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned MaxRowWidth  = 4096;

  localparam int unsigned RowW      = 13;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // effective width limit, kept inside the row counter range
  localparam logic [RowW-1:0] MaxRowW =
      RowW'((MaxRowWidth > ((1 << RowW) - 1)) ? ((1 << RowW) - 1) : MaxRowWidth);

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgPixelFormat = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgKeyEnable   = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgKeyValue    = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgRowWidth    = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgStartPhase  = 3'd4;

  typedef enum logic [1:0] {
    FmtRgb565 = 2'd0,
    FmtIndex8 = 2'd1,
    FmtGray4  = 2'd2,
    FmtIndex5 = 2'd3
  } pix_fmt_e;

  typedef enum logic [1:0] {
    OpPalWrite = 2'd0,
    OpLookup   = 2'd1,
    OpDirect   = 2'd2
  } op_kind_e;

  // one palette access: a table write, a lookup or a ready-made color
  typedef struct packed {
    op_kind_e    kind;
    logic [7:0]  idx;
    logic [15:0] data;
    logic        pix_write;
    logic        row_last;
    logic        item_last;
  } op_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  palette_index;
    logic [15:0] palette_color;
    logic [15:0] source_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic        pixel_write;
    logic        row_last;
    logic        item_last;
  } out_item_t;

endpackage

// File: src/ipe_palette_ram.sv
// palette storage: one write port, one read port, registered read data
// depends on nothing but its parameters
module ipe_palette_ram #(
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [15:0]       wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [15:0]       rdata_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ipe_decode.sv
// configuration registers, row sequencing state and byte unpacking
// into at most two palette ops per word; uses ipe_pkg
module ipe_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ipe_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ipe_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          accept_i,
  input  ipe_pkg::in_item_t             item_i,
  output ipe_pkg::op_t                  op0_o,
  output ipe_pkg::op_t                  op1_o,
  output logic [1:0]                    op_cnt_o
);

  ipe_pkg::pix_fmt_e             fmt_q;
  logic                          key_en_q;
  logic [15:0]                   key_q;
  logic [ipe_pkg::RowW-1:0]      row_width_q;
  logic [2:0]                    phase_q;

  logic [2:0]                    pos_q, pos_d;
  logic [3:0]                    carry_q, carry_d;
  logic [ipe_pkg::RowW-1:0]      done_q, done_d;
  logic                          start_q, start_d;

  ipe_pkg::op_t                  c0, c1, s0, s1;
  logic                          v0, v1;
  logic [7:0]                    b;
  logic [4:0]                    i0, i1;
  logic                          two;
  logic [3:0]                    base;
  logic [ipe_pkg::RowW-1:0]      w;
  logic                          hit0, hit1, restart;
  logic [1:0]                    cnt;

  function automatic logic [15:0] gray565(logic [3:0] nib);
    logic [3:0] g;
    g = ~nib;
    return {g, g[3], g, g[3:2], g, g[3]};
  endfunction

  assign b = item_i.source_data[7:0];

  assign w = (row_width_q == '0) ? ipe_pkg::RowW'(1) :
             ((row_width_q > ipe_pkg::MaxRowW) ? ipe_pkg::MaxRowW : row_width_q);

  // unpack the word into candidate pixels
  always_comb begin
    c0      = '0;
    c1      = '0;
    v0      = 1'b0;
    v1      = 1'b0;
    i0      = '0;
    i1      = '0;
    two     = 1'b0;
    base    = '0;
    pos_d   = pos_q;
    carry_d = carry_q;
    start_d = start_q;
    c0.kind = ipe_pkg::OpDirect;
    c1.kind = ipe_pkg::OpDirect;
    case (fmt_q)
      ipe_pkg::FmtRgb565: begin
        c0.data      = item_i.source_data;
        c0.pix_write = !(key_en_q && item_i.source_data == key_q);
        v0           = 1'b1;
        start_d      = 1'b0;
      end
      ipe_pkg::FmtIndex8: begin
        c0.kind      = ipe_pkg::OpLookup;
        c0.idx       = b;
        c0.pix_write = !(key_en_q && b == key_q[7:0]);
        v0           = 1'b1;
        start_d      = 1'b0;
      end
      ipe_pkg::FmtGray4: begin
        c0.data      = gray565(b[7:4]);
        c0.pix_write = 1'b1;
        c1.data      = gray565(b[3:0]);
        c1.pix_write = 1'b1;
        v0           = !(start_q && phase_q[0]);
        v1           = 1'b1;
        start_d      = 1'b0;
      end
      default: begin
        // five-bit indices, eight per five-byte group, msb first
        unique case (pos_q)
          3'd0: begin
            i0 = b[7:3];           base = 4'd0; carry_d = {1'b0, b[2:0]};
          end
          3'd1: begin
            i0 = {carry_q[2:0], b[7:6]}; i1 = b[5:1]; two = 1'b1;
            base = 4'd1; carry_d = {3'b0, b[0]};
          end
          3'd2: begin
            i0 = {carry_q[0], b[7:4]};   base = 4'd3; carry_d = b[3:0];
          end
          3'd3: begin
            i0 = {carry_q[3:0], b[7]};   i1 = b[6:2]; two = 1'b1;
            base = 4'd4; carry_d = {2'b0, b[1:0]};
          end
          default: begin
            i0 = {carry_q[1:0], b[7:5]}; i1 = b[4:0]; two = 1'b1;
            base = 4'd6; carry_d = '0;
          end
        endcase
        c0.kind      = ipe_pkg::OpLookup;
        c0.idx       = {3'b0, i0};
        c0.pix_write = !(key_en_q && {3'b0, i0} == key_q[7:0]);
        c1.kind      = ipe_pkg::OpLookup;
        c1.idx       = {3'b0, i1};
        c1.pix_write = !(key_en_q && {3'b0, i1} == key_q[7:0]);
        // leading pixels of the first group are skipped
        v0 = !(start_q && base < {1'b0, phase_q});
        v1 = two && !(start_q && (base + 4'd1) < {1'b0, phase_q});
        if (pos_q >= 3'd4) begin
          pos_d   = '0;
          start_d = 1'b0;
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end
    endcase
  end

  // row counting, truncation at row end and op packing
  always_comb begin
    s0      = v0 ? c0 : c1;
    s1      = c1;
    hit0    = ({1'b0, done_q} + 14'd1) >= {1'b0, w};
    hit1    = ({1'b0, done_q} + 14'd2) >= {1'b0, w};
    restart = 1'b0;
    done_d  = done_q;
    cnt     = 2'd0;
    if (v0 || v1) begin
      if (hit0) begin
        s0.row_last  = 1'b1;
        s0.item_last = 1'b1;
        restart      = 1'b1;
        cnt          = 2'd1;
      end else if (v0 && v1) begin
        s1.row_last  = hit1;
        s1.item_last = 1'b1;
        restart      = hit1;
        done_d       = done_q + ipe_pkg::RowW'(2);
        cnt          = 2'd2;
      end else begin
        s0.item_last = 1'b1;
        done_d       = done_q + ipe_pkg::RowW'(1);
        cnt          = 2'd1;
      end
    end
    if (!item_i.action) begin
      s0           = '0;
      s0.kind      = ipe_pkg::OpPalWrite;
      s0.idx       = item_i.palette_index;
      s0.data      = item_i.palette_color;
      cnt          = 2'd1;
    end
  end

  assign op0_o    = s0;
  assign op1_o    = s1;
  assign op_cnt_o = cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= ipe_pkg::FmtRgb565;
      key_en_q    <= 1'b0;
      key_q       <= '0;
      row_width_q <= ipe_pkg::RowW'(1);
      phase_q     <= '0;
      pos_q       <= '0;
      carry_q     <= '0;
      done_q      <= '0;
      start_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ipe_pkg::CfgPixelFormat: fmt_q <= ipe_pkg::pix_fmt_e'(cfg_data_i[1:0]);
        ipe_pkg::CfgKeyEnable:   key_en_q <= cfg_data_i[0];
        ipe_pkg::CfgKeyValue:    key_q <= cfg_data_i;
        ipe_pkg::CfgRowWidth:    row_width_q <= cfg_data_i[ipe_pkg::RowW-1:0];
        ipe_pkg::CfgStartPhase:  phase_q <= cfg_data_i[2:0];
        default: ;
      endcase
      if (cfg_index_i == ipe_pkg::CfgPixelFormat || cfg_index_i == ipe_pkg::CfgRowWidth ||
          cfg_index_i == ipe_pkg::CfgStartPhase) begin
        pos_q   <= '0;
        carry_q <= '0;
        done_q  <= '0;
        start_q <= 1'b1;
      end
    end else if (accept_i && item_i.action) begin
      if (restart) begin
        pos_q   <= '0;
        carry_q <= '0;
        done_q  <= '0;
        start_q <= 1'b1;
      end else begin
        pos_q   <= pos_d;
        carry_q <= carry_d;
        done_q  <= done_d;
        start_q <= start_d;
      end
    end
  end

endmodule

// File: src/ipe_op_queue.sv
// two-entry op buffer between decode and the palette port
// issues one op per cycle in order while the palette port is ready; uses ipe_pkg
module ipe_op_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ipe_pkg::op_t  op0_i,
  input  ipe_pkg::op_t  op1_i,
  input  logic [1:0]    op_cnt_i,
  output logic          can_load_o,
  output logic          issue_valid_o,
  output ipe_pkg::op_t  issue_op_o,
  input  logic          issue_ready_i
);

  ipe_pkg::op_t slot0_q, slot1_q;
  logic [1:0]   cnt_q;
  logic         issue;

  assign issue_valid_o = cnt_q != 2'd0;
  assign issue_op_o    = slot0_q;
  assign issue         = issue_valid_o && issue_ready_i;
  assign can_load_o    = (cnt_q == 2'd0) || (cnt_q == 2'd1 && issue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= op_cnt_i;
    end else if (issue) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= op0_i;
      slot1_q <= op1_i;
    end else if (issue) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

// File: src/ipe_lookup.sv
// palette port, read stage and output register
// uses ipe_pkg and ipe_palette_ram
module ipe_lookup #(
  parameter int unsigned PaletteDepth = ipe_pkg::PaletteDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               issue_valid_i,
  input  ipe_pkg::op_t       op_i,
  output logic               issue_ready_o,
  output logic               out_valid_o,
  output ipe_pkg::out_item_t out_item_o,
  input  logic               out_ready_i
);

  localparam int unsigned AddrW = $clog2(PaletteDepth);

  ipe_pkg::op_t       m_op_q;
  logic               m_valid_q;
  logic               m_oob_q;
  logic               out_valid_q;
  ipe_pkg::out_item_t out_q;

  logic               out_take, m_adv, m_free, fire, oob;
  logic               we, re;
  logic [15:0]        rdata;
  ipe_pkg::out_item_t formed;

  assign out_take = !out_valid_q || out_ready_i;
  assign m_adv    = m_valid_q && out_take;
  assign m_free   = !m_valid_q || out_take;
  // table writes never enter the read stage
  assign issue_ready_o = (op_i.kind == ipe_pkg::OpPalWrite) || m_free;
  assign fire = issue_valid_i && issue_ready_o;
  assign oob  = {1'b0, op_i.idx} >= 9'(PaletteDepth);
  assign we   = fire && op_i.kind == ipe_pkg::OpPalWrite && !oob;
  assign re   = fire && op_i.kind == ipe_pkg::OpLookup;

  ipe_palette_ram #(
    .Depth (PaletteDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (op_i.idx[AddrW-1:0]),
    .wdata_i (op_i.data),
    .re_i    (re),
    .raddr_i (op_i.idx[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    formed.pixel_write = m_op_q.pix_write;
    formed.row_last    = m_op_q.row_last;
    formed.item_last   = m_op_q.item_last;
    if (m_op_q.kind == ipe_pkg::OpDirect) begin
      formed.pixel_color = m_op_q.data;
    end else begin
      formed.pixel_color = m_oob_q ? 16'h0000 : rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire && op_i.kind != ipe_pkg::OpPalWrite) begin
        m_valid_q <= 1'b1;
      end else if (m_adv) begin
        m_valid_q <= 1'b0;
      end
      if (m_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && op_i.kind != ipe_pkg::OpPalWrite) begin
      m_op_q  <= op_i;
      m_oob_q <= oob;
    end
    if (m_adv) begin
      out_q <= formed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: src/indexed_pixel_expander.sv
// top level of the indexed pixel expander
// uses ipe_pkg, ipe_decode, ipe_op_queue and ipe_lookup
//
// Expands a source stream into RGB565 pixel words, row_width pixels per row.
// Each accepted word is unpacked at once into at most two palette ops (table
// write, lookup or direct color) held in a two-entry buffer; the single
// palette port takes one op per cycle while the read stage can accept it,
// so a word that gives two pixels is issued as two ops. A pixel passes the
// op buffer, the read stage and the output register, which lets a new word
// in while a finished pixel still waits. The palette has no reset and needs
// no clearing pass; an entry must be written before it is looked up. The
// user must see that configuration is written only while the block is idle
// (not enforced here); pixel_format, row_width and start_phase restart the row.
module indexed_pixel_expander #(
  parameter int unsigned PaletteDepth = ipe_pkg::PaletteDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ipe_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ipe_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [ipe_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ipe_pkg::CfgDataW-1:0]  cfg_data_i
);

  ipe_pkg::op_t op0, op1, issue_op;
  logic [1:0]   op_cnt;
  logic         can_load, accept, issue_valid, issue_ready;

  assign in_ready_o = can_load;
  assign accept     = in_valid_i && can_load;

  ipe_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .op0_o       (op0),
    .op1_o       (op1),
    .op_cnt_o    (op_cnt)
  );

  ipe_op_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .op0_i         (op0),
    .op1_i         (op1),
    .op_cnt_i      (op_cnt),
    .can_load_o    (can_load),
    .issue_valid_o (issue_valid),
    .issue_op_o    (issue_op),
    .issue_ready_i (issue_ready)
  );

  ipe_lookup #(
    .PaletteDepth (PaletteDepth)
  ) u_lookup (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_valid_i (issue_valid),
    .op_i          (issue_op),
    .issue_ready_o (issue_ready),
    .out_valid_o   (out_valid_o),
    .out_item_o    (out_item_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

// File: src/ipe_checker.sv
// port-level checks of the indexed pixel expander and their bind
// uses ipe_pkg; sees only the top level ports
module ipe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input ipe_pkg::in_item_t             in_item_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input ipe_pkg::out_item_t            out_item_o,
  input logic                          cfg_we_i,
  input logic [ipe_pkg::CfgIndexW-1:0] cfg_index_i,
  input logic [ipe_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [1:0] fmt_q;

  // shadow of the format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= ipe_pkg::FmtRgb565;
    end else if (cfg_we_i && cfg_index_i == ipe_pkg::CfgPixelFormat) begin
      fmt_q <= cfg_data_i[1:0];
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("waiting input word changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output word changed");

  a_row_ends_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.row_last |-> out_item_o.item_last)
    else $error("row end not on last pixel of its word");

  a_gray_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fmt_q == ipe_pkg::FmtGray4 |->
      out_item_o.pixel_write &&
      out_item_o.pixel_color[15:11] == out_item_o.pixel_color[4:0])
    else $error("gray pixel malformed or keyed");

endmodule

bind indexed_pixel_expander ipe_checker u_checker (.*);

// File: tb/sv/tb_indexed_pixel_expander.sv
// self-checking testbench of indexed_pixel_expander: directed and random words,
// scoreboard class with its own pixel expansion model, random idling on both sides
// depends on ipe_pkg and the indexed_pixel_expander rtl
`timescale 1ns / 100ps

module tb_indexed_pixel_expander;
  import ipe_pkg::*;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongHold     = 60;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned NumPhases    = 13;
  localparam int unsigned PhaseWords   = 36;
  localparam int unsigned TailWords    = 48;
  localparam int unsigned MaxReports   = 30;

  class pixel_scoreboard;
    logic [15:0] palette_mem [PaletteDepth];
    logic [2:0]  grp_pos;
    logic [3:0]  carry;
    int unsigned px_in_row;
    bit          at_row_start;
    pix_fmt_e    fmt;
    bit          key_en;
    logic [15:0] key_val;
    logic [12:0] width;
    logic [2:0]  phase;
    out_item_t   expected_pixels [$];
    int unsigned errors, words_seen, palette_writes, pixels_checked, transparent, row_ends;

    function new();
      fmt     = FmtRgb565;
      key_en  = 1'b0;
      key_val = '0;
      width   = 13'd1;
      phase   = '0;
      restart();
    endfunction

    function void restart();
      grp_pos      = '0;
      carry        = '0;
      px_in_row    = 0;
      at_row_start = 1'b1;
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgPixelFormat: begin
          fmt = pix_fmt_e'(data[1:0]);
          restart();
        end
        CfgKeyEnable: key_en = data[0];
        CfgKeyValue:  key_val = data;
        CfgRowWidth: begin
          width = data[12:0];
          restart();
        end
        CfgStartPhase: begin
          phase = data[2:0];
          restart();
        end
        default: ;
      endcase
    endfunction

    // gray level is the inverted nibble, bit-replicated into 5/6/5
    function logic [15:0] gray_of(logic [3:0] nib);
      logic [3:0] g;
      g = 4'hF - nib;
      return {g, g[3], g, g[3:2], g, g[3]};
    endfunction

    function void note_word(in_item_t w);
      logic [15:0] color [2];
      bit          wr [2];
      logic [4:0]  idx [2];
      logic [7:0]  b;
      int          cnt, nidx, base, lim, i, k;
      bit          first;
      out_item_t   px;
      cnt = 0;
      nidx = 0;
      base = 0;
      words_seen++;
      if (!w.action) begin
        palette_mem[w.palette_index] = w.palette_color;
        palette_writes++;
        return;
      end
      b = w.source_data[7:0];
      first = at_row_start;
      case (fmt)
        FmtRgb565: begin
          color[0] = w.source_data;
          wr[0] = !(key_en && w.source_data == key_val);
          cnt = 1;
          at_row_start = 1'b0;
        end
        FmtIndex8: begin
          color[0] = palette_mem[b];
          wr[0] = !(key_en && b == key_val[7:0]);
          cnt = 1;
          at_row_start = 1'b0;
        end
        FmtGray4: begin
          // odd start phase drops the high nibble of the first byte in a row
          if (!(first && phase[0])) begin
            color[cnt] = gray_of(b[7:4]);
            wr[cnt] = 1'b1;
            cnt++;
          end
          color[cnt] = gray_of(b[3:0]);
          wr[cnt] = 1'b1;
          cnt++;
          at_row_start = 1'b0;
        end
        default: begin
          // eight 5-bit indices per five bytes, msb first
          case (grp_pos)
            3'd0: begin
              idx[0] = b[7:3]; nidx = 1; base = 0; carry = {1'b0, b[2:0]};
            end
            3'd1: begin
              idx[0] = {carry[2:0], b[7:6]}; idx[1] = b[5:1];
              nidx = 2; base = 1; carry = {3'b0, b[0]};
            end
            3'd2: begin
              idx[0] = {carry[0], b[7:4]}; nidx = 1; base = 3; carry = b[3:0];
            end
            3'd3: begin
              idx[0] = {carry[3:0], b[7]}; idx[1] = b[6:2];
              nidx = 2; base = 4; carry = {2'b0, b[1:0]};
            end
            default: begin
              idx[0] = {carry[1:0], b[7:5]}; idx[1] = b[4:0];
              nidx = 2; base = 6; carry = '0;
            end
          endcase
          for (k = 0; k < nidx; k++) begin
            if (!(first && (base + k) < int'(phase))) begin
              color[cnt] = palette_mem[idx[k]];
              wr[cnt] = !(key_en && {3'b0, idx[k]} == key_val[7:0]);
              cnt++;
            end
          end
          if (grp_pos >= 3'd4) begin
            grp_pos = '0;
            at_row_start = 1'b0;
          end else begin
            grp_pos = grp_pos + 3'd1;
          end
        end
      endcase

      lim = (width == 0) ? 1 : (width > MaxRowWidth) ? int'(MaxRowWidth) : int'(width);
      for (i = 0; i < cnt; i++) begin
        px_in_row++;
        px.pixel_color = color[i];
        px.pixel_write = wr[i];
        px.row_last    = (px_in_row >= lim);
        px.item_last   = px.row_last || (i == cnt - 1);
        expected_pixels.push_back(px);
        // the rest of the byte is dropped once the row is full
        if (px.row_last) begin
          restart();
          break;
        end
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t exp_px;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected pixel word: color %h write %b row_last %b item_last %b",
                   $time, got.pixel_color, got.pixel_write, got.row_last, got.item_last);
        return;
      end
      exp_px = expected_pixels.pop_front();
      pixels_checked++;
      if (!exp_px.pixel_write) transparent++;
      if (exp_px.row_last) row_ends++;
      if (got.pixel_color !== exp_px.pixel_color || got.pixel_write !== exp_px.pixel_write ||
          got.row_last !== exp_px.row_last || got.item_last !== exp_px.item_last) begin
        errors++;
        if (errors <= MaxReports)
          $display({"%0t: pixel mismatch: expected color %h write %b row_last %b item_last %b,",
                    " got color %h write %b row_last %b item_last %b"}, $time,
                   exp_px.pixel_color, exp_px.pixel_write, exp_px.row_last, exp_px.item_last,
                   got.pixel_color, got.pixel_write, got.row_last, got.item_last);
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  pixel_scoreboard sb = new();
  bit              idle_on = 1'b0;
  bit              hold_req = 1'b0;
  int unsigned     stall_cycles = 0;

  indexed_pixel_expander DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) sb.set_reg(cfg_index_i, cfg_data_i);
    if (rst_ni && in_valid_i && in_ready_o) sb.note_word(in_item_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_pixel(out_item_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("%0t: no word moved for %0d cycles", $time, StallLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stall bursts, and one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_word(in_item_t w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_source(logic [15:0] d);
    in_item_t w;
    w.action        = 1'b1;
    w.palette_index = 8'($urandom);
    w.palette_color = 16'($urandom);
    w.source_data   = d;
    send_word(w);
  endtask

  task automatic send_palette(logic [7:0] a, logic [15:0] c);
    in_item_t w;
    w.action        = 1'b0;
    w.palette_index = a;
    w.palette_color = c;
    w.source_data   = 16'($urandom);
    send_word(w);
  endtask

  // wait until every expected pixel is out and the pipeline has emptied
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // key-only updates leave the row position alone
  task automatic set_config(bit full, pix_fmt_e f, bit ke, logic [15:0] kv,
                            logic [12:0] w, logic [2:0] ph);
    drain();
    if (full) write_reg(CfgPixelFormat, {14'd0, f});
    write_reg(CfgKeyEnable, {15'd0, ke});
    write_reg(CfgKeyValue, kv);
    if (full) begin
      write_reg(CfgRowWidth, {3'd0, w});
      write_reg(CfgStartPhase, {13'd0, ph});
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t make_word(pix_fmt_e f, logic [15:0] kv);
    in_item_t w;
    w.action        = ($urandom_range(0, 9) != 0);
    w.palette_index = 8'($urandom);
    w.palette_color = 16'($urandom);
    w.source_data   = 16'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      if (f == FmtRgb565) w.source_data = kv;
      else w.source_data[7:0] = kv[7:0];
    end
    return w;
  endfunction

  initial begin
    pix_fmt_e    fmt;
    logic [15:0] kv;
    logic [12:0] row_w;
    logic [2:0]  ph;
    bit          full;
    int unsigned settings;
    int          i, p;

    settings = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;

    // fill the whole palette so no lookup ever hits an unwritten entry
    for (i = 0; i < int'(PaletteDepth); i++) begin
      if (i == 0) send_palette(8'(i), 16'h0000);
      else if (i == PaletteDepth - 1) send_palette(8'(i), 16'hFFFF);
      else send_palette(8'(i), 16'($urandom));
    end

    // direct words with a full 16-bit key
    set_config(1'b1, FmtRgb565, 1'b1, 16'hFFFF, 13'd3, 3'd0);
    settings++;
    send_source(16'h0000);
    send_source(16'hFFFF);
    send_source(16'h8001);
    send_source(16'h7FFE);

    // 8-bit index, zero width acts as one, key compares only the low byte
    set_config(1'b1, FmtIndex8, 1'b1, 16'hAB05, 13'd0, 3'd5);
    settings++;
    send_source(16'h0000);
    send_source(16'h00FF);
    send_source(16'hFF05);
    send_source(16'h1234);

    // gray, odd start phase, row ends at the end of a byte
    set_config(1'b1, FmtGray4, 1'b1, 16'h000F, 13'd5, 3'd1);
    settings++;
    send_source(16'h000F);
    send_source(16'hFFF0);
    send_source(16'h00A5);
    send_source(16'h003C);

    // packed 5-bit, largest start phase, key on index 31
    set_config(1'b1, FmtIndex5, 1'b1, 16'h001F, 13'd9, 3'd7);
    settings++;
    send_source(16'h00FF);
    send_source(16'h0000);
    send_source(16'h00AA);
    send_source(16'h0055);
    send_source(16'h00F0);
    send_source(16'hFFFF);
    send_source(16'h0008);
    send_source(16'h0042);
    send_source(16'h0081);
    send_source(16'h001F);

    fmt   = FmtIndex5;
    kv    = 16'h001F;
    row_w = 13'd9;
    ph    = 3'd7;
    for (p = 0; p < int'(NumPhases); p++) begin
      full = (p == 0) || ($urandom_range(0, 3) != 0);
      if (full) begin
        fmt = pix_fmt_e'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0:       row_w = 13'd0;
          1:       row_w = 13'd1;
          default: row_w = 13'($urandom_range(2, 24));
        endcase
        ph = 3'($urandom_range(0, 7));
      end
      kv = 16'($urandom);
      if (fmt == FmtIndex5 && $urandom_range(0, 3) != 0) kv[7:0] = 8'($urandom_range(0, 31));
      idle_on = (p < int'(NumPhases) - 2);
      set_config(full, fmt, 1'($urandom), kv, row_w, ph);
      settings++;
      if (p == 3) hold_req = 1'b1;
      for (i = 0; i < int'(PhaseWords); i++) send_word(make_word(fmt, kv));
    end

    // width register above the limit, long row without an end; gray ignores the key
    set_config(1'b1, FmtGray4, 1'b1, 16'($urandom), 13'h1FFF, 3'd0);
    settings++;
    for (i = 0; i < int'(TailWords); i++) send_source(16'($urandom));
    drain();

    $display("run covered %0d words (%0d palette writes) over %0d register settings",
             sb.words_seen, sb.palette_writes, settings);
    $display("%0d pixels checked, %0d transparent, %0d row ends",
             sb.pixels_checked, sb.transparent, sb.row_ends);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
